[rtl/c2d_pkg.sv]
// Shared constants and types for the conv2d engine.
package c2d_pkg;

    localparam int MaxCin    = 16;
    localparam int MaxCout   = 16;
    localparam int MaxRows   = 32;
    localparam int MaxCols   = 32;
    localparam int MaxKernel = 7;
    localparam int FracBits  = 8;
    localparam int AccW      = 40;

    localparam int CinW  = $clog2(MaxCin);
    localparam int CoutW = $clog2(MaxCout);
    localparam int RowW  = $clog2(MaxRows);
    localparam int ColW  = $clog2(MaxCols);
    localparam int KW    = $clog2(MaxKernel);

    localparam int ActDepth = MaxCin * MaxRows * MaxCols;
    localparam int WgtDepth = MaxCout * MaxCin * MaxKernel * MaxKernel;
    localparam int ActAw    = $clog2(ActDepth);
    localparam int WgtAw    = $clog2(WgtDepth);

    localparam int CfgIdxW = 3;
    localparam int InDataW = 40; // 36 bits of fields padded to bytes
    localparam int OutDataW = 16;

    typedef enum logic [1:0] {
        OP_LOAD_WGT = 2'd0,
        OP_LOAD_BIAS = 2'd1,
        OP_LOAD_ACT = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_IN_CHANNELS  = 3'd0,
        REG_IN_HEIGHT    = 3'd1,
        REG_IN_WIDTH     = 3'd2,
        REG_OUT_CHANNELS = 3'd3,
        REG_KERNEL_SIZE  = 3'd4,
        REG_PADDING      = 3'd5,
        REG_STRIDE       = 3'd6,
        REG_DILATION     = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_TAP,
        ST_MAC,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

[rtl/conv2d_engine_top.sv]
// Conv2d engine: loads stores and computes one output pixel per compute transfer.
//  channel   signals                       payload
//  s_axis    s_axis_tvalid/tready/tdata    op,out_ch,in_ch,row,col,value
//  m_axis    m_axis_tvalid/tready/tdata    result; tuser = status,saturated
//  cfg       cfg_valid/ready/index/data    register writes
// Loads are written on the transfer. A compute reads the bias, then per tap reads
// the stores and accumulates through a single multiplier, then saturates; with no
// taps it goes from the bias read straight to saturation.
// Out-of-range requests answer the cycle after the transfer.
// rst_n clears control and registers to defaults; the stores are not cleared.
// The input side is not ready while a compute runs or a result is unread.
module conv2d_engine_top
    import c2d_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // op[1:0], out_ch[5:2], in_ch[9:6], row[14:10], col[19:15], value[35:20]
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result[15:0]
    output logic [OutDataW-1:0] m_axis_tdata,
    // status[0], saturated[1]
    output logic [1:0]          m_axis_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [4:0] in_channels_reg, out_channels_reg;
    logic [5:0] in_height_reg, in_width_reg;
    logic [2:0] kernel_size_reg, stride_reg;
    logic [1:0] padding_reg, dilation_reg;

    logic signed [15:0] act_mem [ActDepth];
    logic signed [15:0] wgt_mem [WgtDepth];
    logic signed [15:0] bias_mem [MaxCout];

    state_t state_reg, state_next;

    logic [1:0]       in_op;
    logic [CoutW-1:0] in_oc;
    logic [CinW-1:0]  in_ic;
    logic [4:0]       in_row, in_col;
    logic signed [15:0] in_val;
    logic s_fire, m_fire;

    assign in_op  = s_axis_tdata[1:0];
    assign in_oc  = s_axis_tdata[5:2];
    assign in_ic  = s_axis_tdata[9:6];
    assign in_row = s_axis_tdata[14:10];
    assign in_col = s_axis_tdata[19:15];
    assign in_val = s_axis_tdata[35:20];

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_channels_reg <= 5'd1;
            in_height_reg <= 6'd32;
            in_width_reg <= 6'd32;
            out_channels_reg <= 5'd1;
            kernel_size_reg <= 3'd3;
            padding_reg <= 2'd1;
            stride_reg <= 3'd1;
            dilation_reg <= 2'd1;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_IN_CHANNELS:  in_channels_reg <= cfg_data[4:0];
                REG_IN_HEIGHT:    in_height_reg <= cfg_data[5:0];
                REG_IN_WIDTH:     in_width_reg <= cfg_data[5:0];
                REG_OUT_CHANNELS: out_channels_reg <= cfg_data[4:0];
                REG_KERNEL_SIZE:  kernel_size_reg <= cfg_data[2:0];
                REG_PADDING:      padding_reg <= cfg_data[1:0];
                REG_STRIDE:       stride_reg <= cfg_data[2:0];
                REG_DILATION:     dilation_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective (clamped) configuration.
    logic [5:0] cin_e, cout_e, h_e, w_e;
    logic [2:0] k_e, s_e;
    assign cin_e  = (in_channels_reg > 5'd16) ? 6'd16 : {1'b0, in_channels_reg};
    assign cout_e = (out_channels_reg > 5'd16) ? 6'd16 : {1'b0, out_channels_reg};
    assign h_e    = (in_height_reg > 6'd32) ? 6'd32 : in_height_reg;
    assign w_e    = (in_width_reg > 6'd32) ? 6'd32 : in_width_reg;
    assign k_e    = (kernel_size_reg == 3'd0) ? 3'd0 : kernel_size_reg;
    assign s_e    = (stride_reg == 3'd0) ? 3'd1 : stride_reg;

    // Largest row/col index still inside the output: pos*s <= n+2p-d(k-1)-1.
    logic signed [8:0] span_h, span_w, dk;
    assign dk = $signed({7'd0, dilation_reg}) *
                ($signed({6'd0, k_e}) - 9'sd1);
    assign span_h = $signed({3'd0, h_e}) + $signed({6'd0, padding_reg, 1'b0})
                    - dk - 9'sd1;
    assign span_w = $signed({3'd0, w_e}) + $signed({6'd0, padding_reg, 1'b0})
                    - dk - 9'sd1;

    // Compute item registers.
    logic [CoutW-1:0] oc_reg;
    logic [4:0]       row_reg, col_reg;
    logic [CinW:0]    c_reg, c_next;
    logic [2:0]       kh_reg, kh_next, kw_reg, kw_next;
    logic signed [AccW-1:0] acc_reg, acc_next;
    logic             tap_ok_reg;
    logic [ActAw-1:0] act_addr;
    logic [WgtAw-1:0] wgt_addr;
    logic signed [15:0] act_q_reg, wgt_q_reg, bias_q_reg;
    logic [15:0] res_reg;
    logic [1:0]  user_reg;
    logic        res_valid_reg;

    // Tap position from current counters.
    logic signed [9:0] ih, iw;
    logic tap_in;
    assign ih = $signed({5'd0, row_reg}) * $signed({7'd0, s_e})
              + $signed({7'd0, kh_reg}) * $signed({8'd0, dilation_reg})
              - $signed({8'd0, padding_reg});
    assign iw = $signed({5'd0, col_reg}) * $signed({7'd0, s_e})
              + $signed({7'd0, kw_reg}) * $signed({8'd0, dilation_reg})
              - $signed({8'd0, padding_reg});
    assign tap_in = (ih >= 0) && (ih < $signed({4'd0, h_e})) &&
                    (iw >= 0) && (iw < $signed({4'd0, w_e}));

    assign act_addr = {c_reg[CinW-1:0], ih[4:0], iw[4:0]};
    assign wgt_addr = WgtAw'((({oc_reg, c_reg[CinW-1:0]} * 7) + kh_reg) * 7 + kw_reg);

    logic in_range;
    logic signed [12:0] rs_h, rs_w;
    assign rs_h = $signed({8'd0, in_row}) * $signed({10'd0, s_e});
    assign rs_w = $signed({8'd0, in_col}) * $signed({10'd0, s_e});
    assign in_range = ({2'd0, in_oc} < cout_e) && (span_h >= 0) && (span_w >= 0) &&
                      (rs_h <= $signed({{4{span_h[8]}}, span_h})) &&
                      (rs_w <= $signed({{4{span_w[8]}}, span_w}));

    logic last_tap;
    assign last_tap = (kw_reg == k_e - 3'd1) && (kh_reg == k_e - 3'd1) &&
                      (c_reg == cin_e[CinW:0] - 1'b1);

    // Store writes and registered reads.
    always_ff @(posedge clk) begin
        if (s_fire && in_op == OP_LOAD_WGT && in_row < 5'd7 && in_col < 5'd7) begin
            wgt_mem[WgtAw'((({in_oc, in_ic} * 7) + in_row) * 7 + in_col)] <= in_val;
        end
        if (s_fire && in_op == OP_LOAD_ACT) begin
            act_mem[{in_ic, in_row, in_col}] <= in_val;
        end
        if (s_fire && in_op == OP_LOAD_BIAS) begin
            bias_mem[in_oc] <= in_val;
        end
        act_q_reg <= act_mem[act_addr];
        wgt_q_reg <= wgt_mem[wgt_addr];
        bias_q_reg <= bias_mem[oc_reg];
    end

    // Multiplier product, shared by every tap.
    logic signed [31:0] prod;
    assign prod = act_q_reg * wgt_q_reg;

    // Shift back with floor, saturate.
    logic signed [AccW-FracBits-1:0] q;
    logic sat_hi, sat_lo;
    assign q = (AccW-FracBits)'(acc_reg >>> FracBits);
    assign sat_hi = (q > 32'sd32767);
    assign sat_lo = (q < -32'sd32768);

    always_comb begin
        state_next = state_reg;
        c_next = c_reg;
        kh_next = kh_reg;
        kw_next = kw_reg;
        acc_next = acc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_op == OP_COMPUTE) begin
                    state_next = in_range ? ST_BIAS : ST_OUT;
                end
            end
            ST_BIAS: begin
                c_next = '0;
                kh_next = '0;
                kw_next = '0;
                state_next = ST_TAP;
            end
            ST_TAP: begin
                // bias read lands here on the first pass
                if (c_reg == '0 && kh_reg == '0 && kw_reg == '0) begin
                    acc_next = AccW'(bias_q_reg) <<< FracBits;
                end
                if (cin_e == 6'd0 || k_e == 3'd0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (tap_ok_reg) begin
                    acc_next = acc_reg + AccW'(prod);
                end
                if (last_tap) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MAC;
                    if (kw_reg == k_e - 3'd1) begin
                        kw_next = '0;
                        if (kh_reg == k_e - 3'd1) begin
                            kh_next = '0;
                            c_next = c_reg + 1'b1;
                        end else begin
                            kh_next = kh_reg + 3'd1;
                        end
                    end else begin
                        kw_next = kw_reg + 3'd1;
                    end
                    state_next = ST_TAP;
                end
            end
            ST_FINISH: state_next = ST_OUT;
            ST_OUT: begin
                if (m_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ST_TAP issues the address; ST_MAC consumes the registered read.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_fire && in_op == OP_COMPUTE && !in_range) begin
                res_valid_reg <= 1'b1;
            end else if (state_reg == ST_FINISH) begin
                res_valid_reg <= 1'b1;
            end else if (m_fire) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        c_reg <= c_next;
        kh_reg <= kh_next;
        kw_reg <= kw_next;
        acc_reg <= acc_next;
        if (state_reg == ST_IDLE && s_fire) begin
            oc_reg <= in_oc;
            row_reg <= in_row;
            col_reg <= in_col;
            res_reg <= '0;
            user_reg <= 2'b01;
        end
        if (state_reg == ST_TAP) begin
            tap_ok_reg <= tap_in;
        end
        if (state_reg == ST_FINISH) begin
            res_reg <= sat_hi ? 16'h7fff : (sat_lo ? 16'h8000 : q[15:0]);
            user_reg <= {sat_hi || sat_lo, 1'b0};
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata = res_reg;
    assign m_axis_tuser = user_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
    a_err_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0 && !m_axis_tuser[1]))
        else $error("error result malformed");
`endif

endmodule
